FILE: sv/hvt_pkg.sv
// ----------------------------------------------------------------------------
// hvt_pkg: shared types and constants for the homogeneous vertex transform
// Holds the configuration register map, the identity reset values, the
// default number format and the per-lane result record.
// ----------------------------------------------------------------------------
package hvt_pkg;

    localparam int unsigned N_ROWS         = 4;
    localparam int unsigned N_COLS         = 4;
    localparam int unsigned N_CFG          = 8;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned CFG_DATA_W     = 64;
    localparam int unsigned COMP_W         = 32;
    localparam int unsigned ELEM_WIDTH_DEF = 32;
    localparam int unsigned FRAC_BITS_DEF  = 16;
    localparam int unsigned OQ_DEPTH       = 8;

    // Configuration register map: two matrix elements per register.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0_COLS01 = 3'd0,
        CFG_ROW0_COLS23 = 3'd1,
        CFG_ROW1_COLS01 = 3'd2,
        CFG_ROW1_COLS23 = 3'd3,
        CFG_ROW2_COLS01 = 3'd4,
        CFG_ROW2_COLS23 = 3'd5,
        CFG_ROW3_COLS01 = 3'd6,
        CFG_ROW3_COLS23 = 3'd7
    } t_cfg_idx;

    localparam logic [CFG_DATA_W-1:0] ONE_LOW  = 64'h0000_0000_0001_0000;
    localparam logic [CFG_DATA_W-1:0] ONE_HIGH = 64'h0001_0000_0000_0000;

    // Reset gives the identity matrix in Q16.16.
    function automatic logic [CFG_DATA_W-1:0] cfg_reset_value(input t_cfg_idx idx);
        logic [CFG_DATA_W-1:0] v;
        unique case (idx)
            CFG_ROW0_COLS01: v = ONE_LOW;
            CFG_ROW0_COLS23: v = '0;
            CFG_ROW1_COLS01: v = ONE_HIGH;
            CFG_ROW1_COLS23: v = '0;
            CFG_ROW2_COLS01: v = '0;
            CFG_ROW2_COLS23: v = ONE_LOW;
            CFG_ROW3_COLS01: v = '0;
            CFG_ROW3_COLS23: v = ONE_HIGH;
            default:         v = '0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic              valid;
        logic              ovf;
        logic [COMP_W-1:0] value;
    } t_lane_res;

endpackage

FILE: sv/hvt_lane.sv
// ----------------------------------------------------------------------------
// hvt_lane: one matrix row dotted with the input vector
// Four multipliers, a registered four-term sum, then the arithmetic shift
// and saturation. Three register stages, one item per cycle.
// ----------------------------------------------------------------------------
module hvt_lane
    import hvt_pkg::*;
#(
    parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_kind,
    input  logic                           i_active,
    input  logic [N_COLS-1:0][COMP_W-1:0]  i_vec,
    input  logic [N_COLS-1:0][COMP_W-1:0]  i_row,
    output t_lane_res                      o_res
);

    localparam int unsigned PROD_W = (2 * ELEM_WIDTH > ELEM_WIDTH + FRAC_BITS) ?
                                     2 * ELEM_WIDTH : ELEM_WIDTH + FRAC_BITS;
    localparam int unsigned SUM_W  = PROD_W + 2;
    localparam logic signed [SUM_W-1:0] MAX_V =
        {{(SUM_W - ELEM_WIDTH + 1){1'b0}}, {(ELEM_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] MIN_V = ~MAX_V;

    logic signed [ELEM_WIDTH-1:0]   a_el [N_COLS];
    logic signed [ELEM_WIDTH-1:0]   b_el [N_COLS];
    logic signed [2*ELEM_WIDTH-1:0] mul  [N_COLS];
    logic signed [PROD_W-1:0]       n_prod [N_COLS];
    logic signed [PROD_W-1:0]       r_prod [N_COLS];
    logic signed [SUM_W-1:0]        n_sum, r_sum;
    logic signed [SUM_W-1:0]        shifted;
    logic signed [ELEM_WIDTH-1:0]   sat_el;
    logic                           sat_ovf;
    logic [COMP_W-1:0]              n_val, r_val;
    logic                           n_ovf, r_ovf;
    logic                           r_v1, r_v2, r_v3;
    logic                           r_act1, r_act2;

    // Stage 1: products. For a point the fourth term is the element times one.
    always_comb begin
        for (int c = 0; c < N_COLS; c++) begin
            a_el[c]   = i_row[c][ELEM_WIDTH-1:0];
            b_el[c]   = i_vec[c][ELEM_WIDTH-1:0];
            mul[c]    = a_el[c] * b_el[c];
            n_prod[c] = PROD_W'(mul[c]);
        end
        if (!i_kind) begin
            n_prod[N_COLS-1] = PROD_W'(a_el[N_COLS-1]) <<< FRAC_BITS;
        end
    end

    // Stage 2: exact sum.
    always_comb begin
        n_sum = '0;
        for (int c = 0; c < N_COLS; c++) begin
            n_sum = n_sum + SUM_W'(r_prod[c]);
        end
    end

    // Stage 3: shift towards minus infinity, then saturate.
    always_comb begin
        shifted = r_sum >>> FRAC_BITS;
        sat_ovf = 1'b0;
        sat_el  = shifted[ELEM_WIDTH-1:0];
        if (shifted > MAX_V) begin
            sat_ovf = 1'b1;
            sat_el  = MAX_V[ELEM_WIDTH-1:0];
        end else if (shifted < MIN_V) begin
            sat_ovf = 1'b1;
            sat_el  = MIN_V[ELEM_WIDTH-1:0];
        end
        n_val = r_act2 ? COMP_W'(sat_el) : '0;
        n_ovf = r_act2 & sat_ovf;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_act1 <= i_active;
        r_sum  <= n_sum;
        r_act2 <= r_act1;
        r_val  <= n_val;
        r_ovf  <= n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_res = '{valid: r_v3, ovf: r_ovf, value: r_val};

`ifndef NO_ASSERTIONS
    a_valid_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> $past(i_valid, 3))
        else $error("lane result without a matching input three cycles earlier");

    a_idle_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !r_act2) |=> (r_val == '0 && !r_ovf))
        else $error("unused row produced a value or an overflow");

    a_ovf_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_ovf) |-> (r_val == COMP_W'(sat_el) || r_val == COMP_W'(MAX_V[ELEM_WIDTH-1:0])
                             || r_val == COMP_W'(MIN_V[ELEM_WIDTH-1:0]))
        || !(r_v3 && r_ovf))
        else $error("overflow flagged but the value is not a saturation limit");
`endif

endmodule

FILE: sv/hvt_merge.sv
// ----------------------------------------------------------------------------
// hvt_merge: result merge and output queue
// Packs the four lane results into one output transfer, ORs their overflow
// flags and queues the result. A credit count covers items still in the
// lanes so that the queue can never overrun.
// ----------------------------------------------------------------------------
module hvt_merge
    import hvt_pkg::*;
#(
    parameter int unsigned DEPTH = OQ_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_accept,
    output logic                       o_in_ready,
    input  t_lane_res                  i_lanes [N_ROWS],
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [N_ROWS*COMP_W-1:0]   m_axis_tdata,   // out_x, out_y, out_z, out_w
    output logic                       m_axis_tuser    // overflow
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned ENT_W = N_ROWS * COMP_W + 1;

    logic [ENT_W-1:0]  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr, r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_fill, n_fill, r_credit, n_credit;
    logic [N_ROWS*COMP_W-1:0] w_data;
    logic              w_ovf, push, pop;

    always_comb begin
        w_ovf = 1'b0;
        for (int l = 0; l < N_ROWS; l++) begin
            w_ovf = w_ovf | i_lanes[l].ovf;
            w_data[l*COMP_W +: COMP_W] = i_lanes[l].value;
        end
    end

    assign push = i_lanes[0].valid;
    assign pop  = (r_fill != '0) && m_axis_tready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        n_fill   = r_fill + CNT_W'(push) - CNT_W'(pop);
        n_credit = r_credit + CNT_W'(i_in_accept) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= {w_ovf, w_data};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_credit <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
            r_credit <= n_credit;
        end
    end

    // Credits count every item between input transfer and output transfer.
    assign o_in_ready    = r_credit < CNT_W'(DEPTH);
    assign m_axis_tvalid = r_fill != '0;
    assign m_axis_tdata  = r_mem[r_rd_ptr][N_ROWS*COMP_W-1:0];
    assign m_axis_tuser  = r_mem[r_rd_ptr][ENT_W-1];

`ifndef NO_ASSERTIONS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_fill != CNT_W'(DEPTH)))
        else $error("output queue written while full");

    a_fill_within_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_credit)
        else $error("queue holds more results than items accepted");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_lanes[0].valid == i_lanes[1].valid) && (i_lanes[0].valid == i_lanes[2].valid)
        && (i_lanes[0].valid == i_lanes[3].valid))
        else $error("lane results out of step");
`endif

endmodule

FILE: sv/homogeneous_vertex_transform.sv
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform: 4x4 matrix times vector, Q16.16
// Transforms a stream of points or 4-component vectors by a configured
// row-major matrix, with shift, saturation and an overflow flag.
// ----------------------------------------------------------------------------
// One item is taken every clock while s_axis_tready is high. Four row lanes,
// each with four multipliers, take three register stages, and the result
// queue adds one. The queue holds eight results and the block accepts input
// whenever fewer than eight items are between input and output, so a stalled
// output does not stop the input straight away. The matrix resets to the
// identity; write it only while no item is in flight.
module homogeneous_vertex_transform
    import hvt_pkg::*;
#(
    parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [N_COLS*COMP_W-1:0]   s_axis_tdata,   // in_x, in_y, in_z, in_w
    input  logic                       s_axis_tuser,   // kind
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [N_ROWS*COMP_W-1:0]   m_axis_tdata,   // out_x, out_y, out_z, out_w
    output logic                       m_axis_tuser    // overflow
);

    logic [CFG_DATA_W-1:0]            r_cfg [N_CFG];
    logic [N_COLS-1:0][COMP_W-1:0]    w_vec;
    logic                             in_accept;
    t_lane_res                        lane_res [N_ROWS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_CFG; i++) begin
                r_cfg[i] <= cfg_reset_value(t_cfg_idx'(i));
            end
        end else if (i_cfg_valid) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign w_vec     = s_axis_tdata;

    for (genvar r = 0; r < N_ROWS; r++) begin : g_lane
        logic [N_COLS-1:0][COMP_W-1:0] row_el;
        // A point leaves the last row unused.
        logic active;

        assign row_el[0] = r_cfg[2*r][COMP_W-1:0];
        assign row_el[1] = r_cfg[2*r][CFG_DATA_W-1:COMP_W];
        assign row_el[2] = r_cfg[2*r+1][COMP_W-1:0];
        assign row_el[3] = r_cfg[2*r+1][CFG_DATA_W-1:COMP_W];
        assign active    = s_axis_tuser || (r != N_ROWS - 1);

        hvt_lane #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (in_accept),
            .i_kind   (s_axis_tuser),
            .i_active (active),
            .i_vec    (w_vec),
            .i_row    (row_el),
            .o_res    (lane_res[r])
        );
    end

    hvt_merge #(
        .DEPTH (OQ_DEPTH)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_accept   (in_accept),
        .o_in_ready    (s_axis_tready),
        .i_lanes       (lane_res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

FILE: verif/hvt_checker.sv
// ----------------------------------------------------------------------------
// hvt_checker: result predictor and scoreboard for the vertex transform
// Watches the configuration, input and output channels of the block. It keeps
// its own copy of the matrix, predicts each transformed vertex on every input
// transfer and compares every output transfer field by field with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module hvt_checker
    import hvt_pkg::*;
#(
    parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [N_COLS*COMP_W-1:0]   s_axis_tdata,   // in_x, in_y, in_z, in_w
    input  logic                       s_axis_tuser,   // kind
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [N_ROWS*COMP_W-1:0]   m_axis_tdata,   // out_x, out_y, out_z, out_w
    input  logic                       m_axis_tuser,   // overflow
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        logic [COMP_W-1:0] x;
        logic [COMP_W-1:0] y;
        logic [COMP_W-1:0] z;
        logic [COMP_W-1:0] w;
        logic              ovf;
    } t_vertex_res;

    logic [CFG_DATA_W-1:0] matrix_regs [N_CFG];
    t_vertex_res           expected_vertices [$];

    // Takes the low ELEM_WIDTH bits of a half word as a two's complement value.
    function automatic logic signed [63:0] to_fixed(input logic [31:0] raw);
        logic signed [63:0] t;
        t = {raw, 32'd0};
        t = t <<< (32 - ELEM_WIDTH);
        return t >>> (64 - ELEM_WIDTH);
    endfunction

    function automatic t_vertex_res transform_vertex(input logic kind,
                                                     input logic [N_COLS*COMP_W-1:0] data);
        logic signed [63:0]  vec [N_COLS];
        logic signed [127:0] acc;
        logic signed [127:0] max_val;
        logic signed [127:0] min_val;
        logic [COMP_W-1:0]   comp [N_ROWS];
        logic [63:0]         word;
        logic [31:0]         half;
        int                  n_rows;
        t_vertex_res         res;
        max_val = (128'sd1 <<< (ELEM_WIDTH - 1)) - 128'sd1;
        min_val = -max_val - 128'sd1;
        for (int c = 0; c < N_COLS; c++) begin
            vec[c] = to_fixed(data[c*COMP_W +: COMP_W]);
        end
        // A point carries an implied w of 1.0 and leaves the fourth row unused.
        if (!kind) begin
            vec[3] = 64'sd1 <<< FRAC_BITS;
        end
        n_rows = kind ? 4 : 3;
        res.ovf = 1'b0;
        for (int r = 0; r < N_ROWS; r++) begin
            comp[r] = '0;
            if (r < n_rows) begin
                acc = '0;
                for (int c = 0; c < N_COLS; c++) begin
                    word = matrix_regs[r*2 + c/2];
                    half = (c % 2) ? word[63:32] : word[31:0];
                    acc  = acc + to_fixed(half) * vec[c];
                end
                acc = acc >>> FRAC_BITS;
                if (acc > max_val) begin
                    acc     = max_val;
                    res.ovf = 1'b1;
                end else if (acc < min_val) begin
                    acc     = min_val;
                    res.ovf = 1'b1;
                end
                comp[r] = acc[COMP_W-1:0];
            end
        end
        res.x = comp[0];
        res.y = comp[1];
        res.z = comp[2];
        res.w = comp[3];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_vertex_res want;
        t_vertex_res got;
        if (!i_rst_n) begin
            matrix_regs[0] = 64'h0000_0000_0001_0000;
            matrix_regs[1] = 64'h0;
            matrix_regs[2] = 64'h0001_0000_0000_0000;
            matrix_regs[3] = 64'h0;
            matrix_regs[4] = 64'h0;
            matrix_regs[5] = 64'h0000_0000_0001_0000;
            matrix_regs[6] = 64'h0;
            matrix_regs[7] = 64'h0001_0000_0000_0000;
            expected_vertices.delete();
            o_fail_count = 0;
            o_pending   <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                matrix_regs[i_cfg_index] = i_cfg_data;
            end
            // The output side is checked first: a result always belongs to an
            // item accepted at an earlier edge.
            if (m_axis_tvalid && m_axis_tready) begin
                got.x   = m_axis_tdata[0*COMP_W +: COMP_W];
                got.y   = m_axis_tdata[1*COMP_W +: COMP_W];
                got.z   = m_axis_tdata[2*COMP_W +: COMP_W];
                got.w   = m_axis_tdata[3*COMP_W +: COMP_W];
                got.ovf = m_axis_tuser;
                if (expected_vertices.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_REPORTS) begin
                        $display("unexpected result: x=%h y=%h z=%h w=%h ovf=%0d",
                                 got.x, got.y, got.z, got.w, got.ovf);
                    end
                end else begin
                    want = expected_vertices.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                        got.w !== want.w || got.ovf !== want.ovf) begin
                        o_fail_count++;
                        if (o_fail_count <= MAX_REPORTS) begin
                            $display("mismatch: expected x=%h y=%h z=%h w=%h ovf=%0d",
                                     want.x, want.y, want.z, want.w, want.ovf);
                            $display("          actual   x=%h y=%h z=%h w=%h ovf=%0d",
                                     got.x, got.y, got.z, got.w, got.ovf);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_vertices.push_back(transform_vertex(s_axis_tuser, s_axis_tdata));
            end
            o_pending <= expected_vertices.size();
        end
    end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the homogeneous vertex transform
// Drives a directed set of points and vectors, then phases of random vertices
// under a range of matrices from extreme to small, with random idle gaps on
// both stream sides and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;
    import hvt_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 9;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int N_PHASES     = 12;
    localparam int PHASE_ITEMS  = 160;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN  = 32'h8000_0000;
    localparam logic [31:0] Q_ONE  = 32'h0001_0000;
    localparam logic [31:0] Q_NLSB = 32'hFFFF_FFFF;

    localparam logic KIND_POINT  = 1'b0;
    localparam logic KIND_VECTOR = 1'b1;

    typedef enum int {
        MAT_MIXED,
        MAT_MAX,
        MAT_MIN,
        MAT_ZERO,
        MAT_ONES,
        MAT_IDENTITY,
        MAT_SMALL
    } t_matrix_style;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [N_COLS*COMP_W-1:0] s_axis_tdata;
    logic                     s_axis_tuser;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [N_ROWS*COMP_W-1:0] m_axis_tdata;
    logic                     m_axis_tuser;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    bit tx_free;
    bit rx_free;
    bit hold_req;

    homogeneous_vertex_transform i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    hvt_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Ends the run if no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return Q_ONE;
            4, 5:    return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] matrix_elem(input t_matrix_style style);
        case (style)
            MAT_MAX:   return Q_MAX;
            MAT_MIN:   return Q_MIN;
            MAT_ZERO:  return '0;
            MAT_ONES:  return Q_NLSB;
            MAT_SMALL: return $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
            default:   return rand_comp();
        endcase
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_matrix(input t_matrix_style style);
        logic [CFG_DATA_W-1:0] word;
        int                    row;
        for (int i = 0; i < N_CFG; i++) begin
            if (style == MAT_IDENTITY) begin
                // The diagonal element of row r sits in register 2r + r/2.
                row  = i / 2;
                word = (i == row*2 + row/2) ? (64'(Q_ONE) << (32 * (row % 2))) : '0;
                if (i % 2 != row / 2) begin
                    row  = 2 * (i % 2) + (i / 2) % 2;
                end
                word = '0;
                for (int r = 0; r < N_ROWS; r++) begin
                    if (i == r*2 + r/2) word = 64'(Q_ONE) << (32 * (r % 2));
                end
            end else begin
                word = {matrix_elem(style), matrix_elem(style)};
            end
            write_reg(t_cfg_idx'(i), word);
        end
    endtask

    // Offers one vertex, waits for its transfer, then sometimes idles for a random gap.
    task automatic push_vertex(input logic kind, input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic [31:0] w);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {w, z, y, x};
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        gap = tx_free ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops offering and waits until every predicted result has arrived.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Output side: random ready pattern, plus one long hold-off on request.
    initial begin : rx_side
        int  gap;
        int  burst;
        bit  hold_done;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                gap = rx_free ? 0 : pick_gap();
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
                burst = $urandom_range(1, 12);
                repeat (burst) @(posedge i_clk);
            end
        end
    end

    initial begin : tx_side
        t_matrix_style style;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_POINT;
        tx_free       = 1'b0;
        rx_free       = 1'b0;
        hold_req      = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Identity matrix after reset: extremes pass through unchanged, and a
        // point ignores whatever its w field holds.
        push_vertex(KIND_POINT,  '0,     '0,     '0,     Q_MAX);
        push_vertex(KIND_POINT,  Q_MAX,  Q_MAX,  Q_MAX,  Q_MIN);
        push_vertex(KIND_POINT,  Q_MIN,  Q_MIN,  Q_MIN,  '0);
        push_vertex(KIND_VECTOR, Q_MAX,  Q_MAX,  Q_MAX,  Q_MAX);
        push_vertex(KIND_VECTOR, Q_MIN,  Q_MIN,  Q_MIN,  Q_MIN);
        push_vertex(KIND_VECTOR, '0,     '0,     '0,     '0);
        push_vertex(KIND_VECTOR, Q_ONE,  Q_ONE,  Q_ONE,  Q_ONE);
        push_vertex(KIND_VECTOR, Q_NLSB, Q_NLSB, Q_NLSB, Q_NLSB);
        push_vertex(KIND_VECTOR, Q_MAX,  Q_MIN,  Q_ONE,  Q_NLSB);
        push_vertex(KIND_POINT,  Q_ONE,  Q_NLSB, Q_MAX,  $urandom());
        push_vertex(KIND_VECTOR, $urandom(), $urandom(), $urandom(), $urandom());
        push_vertex(KIND_POINT,  $urandom(), $urandom(), $urandom(), $urandom());
        drain();

        // Full-scale matrix: saturation both ways, and a point whose sum is
        // only the column-3 term.
        write_matrix(MAT_MAX);
        push_vertex(KIND_VECTOR, Q_MAX,  Q_MAX,  Q_MAX,  Q_MAX);
        push_vertex(KIND_VECTOR, Q_MIN,  Q_MIN,  Q_MIN,  Q_MIN);
        push_vertex(KIND_POINT,  '0,     '0,     '0,     Q_MAX);
        push_vertex(KIND_VECTOR, '0,     '0,     '0,     '0);
        push_vertex(KIND_POINT,  Q_MAX,  Q_MAX,  Q_MAX,  Q_MIN);
        push_vertex(KIND_VECTOR, Q_MAX,  Q_MIN,  Q_MAX,  Q_MIN);
        drain();

        for (int phase = 0; phase < N_PHASES; phase++) begin
            style   = t_matrix_style'(phase % 7);
            tx_free = ($urandom_range(0, 3) == 0);
            rx_free = ($urandom_range(0, 3) == 0);
            if (phase == 2) begin
                // Keep offering at full rate so the block backs up behind the
                // long hold-off on the output side.
                hold_req = 1'b1;
                tx_free  = 1'b1;
            end
            write_matrix(style);
            repeat (PHASE_ITEMS) begin
                push_vertex(1'($urandom_range(0, 1)), rand_comp(), rand_comp(), rand_comp(),
                            rand_comp());
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/hvt_pkg.sv
sv/hvt_lane.sv
sv/hvt_merge.sv
sv/homogeneous_vertex_transform.sv
verif/hvt_checker.sv
verif/tb.sv
